/* sv/cstp_pkg.sv */
// Shared constants, codes and types of the call stack time profiler.
package cstp_pkg;

  // Stack geometry
  localparam int STACK_DEPTH = 256;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int LVL_W       = $clog2(STACK_DEPTH + 1);

  // Field widths
  localparam int ID_W    = 16;
  localparam int TIME_W  = 64;
  localparam int MEM_W   = 48;
  localparam int DELTA_W = 49;
  localparam int SKIP_W  = 16;

  // Configuration port
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 5;

  localparam logic [CFG_ADDR_W-1:0] REG_ENABLE    = 5'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD = 5'd8;
  localparam logic [CFG_ADDR_W-1:0] REG_SESSION   = 5'd16;

  // Request and record codes
  localparam logic REQ_ENTER  = 1'b0;
  localparam logic REQ_EXIT   = 1'b1;
  localparam logic KIND_ENTER = 1'b0;
  localparam logic KIND_EXIT  = 1'b1;

  localparam logic [SKIP_W-1:0] SKIP_MAX = {SKIP_W{1'b1}};

  // One stack frame as held in the frame memory
  typedef struct packed {
    logic [ID_W-1:0]   func;
    logic [TIME_W-1:0] base_time;
    logic [MEM_W-1:0]  base_mem;
  } frame_t;

endpackage

/* sv/cstp_if.sv */
// Valid/ready channel interfaces for profiler events and records.
interface cstp_in_if
  import cstp_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [ID_W-1:0]   func_id;
  logic [TIME_W-1:0] timestamp_ns;
  logic [MEM_W-1:0]  mem_usage;

  modport source (output valid, req_type, func_id, timestamp_ns, mem_usage, input ready);
  modport sink   (input valid, req_type, func_id, timestamp_ns, mem_usage, output ready);
endinterface

interface cstp_out_if
  import cstp_pkg::*;
  ();
  logic                      valid;
  logic                      ready;
  logic                      event_kind;
  logic [ID_W-1:0]           out_func_id;
  logic [TIME_W-1:0]         inclusive_ns;
  logic [TIME_W-1:0]         exclusive_ns;
  logic signed [DELTA_W-1:0] mem_diff;
  logic [TIME_W-1:0]         session;

  modport source (output valid, event_kind, out_func_id, inclusive_ns, exclusive_ns,
                  mem_diff, session, input ready);
  modport sink   (input valid, event_kind, out_func_id, inclusive_ns, exclusive_ns,
                  mem_diff, session, output ready);
endinterface

/* sv/call_stack_time_profiler.sv */
// Call stack time profiler: frame memories, event sequencer and APB registers.
//
// The block takes one event at a time. An enter that pushes a frame passes
// through S_ENTER, an exit that pops a frame through S_RD and S_FIN, and an
// event that only moves the skip counter or is ignored stays in S_IDLE. A
// record that cannot leave the output register holds S_ENTER or S_FIN until
// out_chan.ready is seen. The steps come from the registered reads of the
// frame and child time memories and from splitting the exit arithmetic over
// S_RD and S_FIN (inclusive time first, then exclusive time, threshold compare
// and the parent's child time update, written back before the next event
// reads). The next event is taken while a record still waits in the output
// register. No clearing pass runs after reset: a frame is always written by
// its push before it is read. Registers: enable (1 bit) at 0x00, and the
// 64-bit threshold at 0x08 and session_tag at 0x10; write them only while idle.
module call_stack_time_profiler
  import cstp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  cstp_in_if.sink               in_chan,
  cstp_out_if.source            out_chan,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  typedef enum logic [1:0] {S_IDLE, S_ENTER, S_RD, S_FIN} state_t;

  // Configuration registers
  logic              enable_r;
  logic [TIME_W-1:0] threshold_r;
  logic [TIME_W-1:0] session_r;

  // Control state
  state_t            state_r;
  logic [LVL_W-1:0]  level_r;
  logic [SKIP_W-1:0] skip_r;

  // Latched request and exit datapath
  logic [ID_W-1:0]    req_id_r;
  logic [TIME_W-1:0]  req_time_r;
  logic [MEM_W-1:0]   req_mem_r;
  logic [ADDR_W-1:0]  parent_r;
  logic               has_parent_r;
  logic [TIME_W-1:0]  incl_r;
  logic [DELTA_W-1:0] mdelta_r;
  logic [ID_W-1:0]    fid_r;

  // Memories and their registered read data
  frame_t            frame_mem [STACK_DEPTH];
  logic [TIME_W-1:0] child_mem [STACK_DEPTH];
  frame_t            frame_rd_r;
  logic [TIME_W-1:0] child_rd_r;
  logic [TIME_W-1:0] parent_rd_r;

  // Output register
  logic                      out_valid_r;
  logic                      out_kind_r;
  logic [ID_W-1:0]           out_id_r;
  logic [TIME_W-1:0]         out_incl_r;
  logic [TIME_W-1:0]         out_excl_r;
  logic signed [DELTA_W-1:0] out_delta_r;
  logic [TIME_W-1:0]         out_session_r;

  logic              in_acc;
  logic              is_enter;
  logic              full;
  logic              push;
  logic              pop;
  logic              out_free;
  logic              out_load;
  logic [ADDR_W-1:0] push_addr;
  logic [ADDR_W-1:0] top_addr;
  logic [ADDR_W-1:0] par_addr;
  logic [TIME_W-1:0] excl;
  logic              emit;
  logic              fin_go;
  logic              child_we;
  logic [ADDR_W-1:0] child_waddr;
  logic [TIME_W-1:0] child_wdata;
  logic              cfg_wr;

  // Decode the accepted event
  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc    = in_chan.valid && in_chan.ready;
  assign is_enter  = (in_chan.req_type == REQ_ENTER);
  assign full      = (level_r == LVL_W'(STACK_DEPTH));
  assign push      = in_acc && enable_r && is_enter && !full;
  assign pop       = in_acc && enable_r && !is_enter && (skip_r == '0) && (level_r != '0);
  assign push_addr = level_r[ADDR_W-1:0];
  assign top_addr  = ADDR_W'(level_r - LVL_W'(1));
  assign par_addr  = top_addr - ADDR_W'(1);
  assign out_free  = !out_valid_r || out_chan.ready;

  // Finish an exit: exclusive time, threshold test, parent update
  assign excl   = incl_r - child_rd_r;
  assign emit   = (excl >= threshold_r) && (fid_r != '0);
  assign fin_go = (state_r == S_FIN) && (!emit || out_free);

  // Load the output register from the enter step or the exit finish
  assign out_load = ((state_r == S_ENTER) && out_free) || (fin_go && emit);

  // Child time write port: clear on push, accumulate into the parent when an exit finishes
  assign child_we    = push || (fin_go && has_parent_r);
  assign child_waddr = push ? push_addr : parent_r;
  assign child_wdata = push ? '0 : parent_rd_r + incl_r;

  // Frame memory
  always_ff @(posedge clk) begin
    if (push) begin
      frame_mem[push_addr] <= '{func: in_chan.func_id,
                                base_time: in_chan.timestamp_ns,
                                base_mem: in_chan.mem_usage};
    end
    if (pop) begin
      frame_rd_r <= frame_mem[top_addr];
    end
  end

  // Child time memory, read at the top and at its parent
  always_ff @(posedge clk) begin
    if (child_we) begin
      child_mem[child_waddr] <= child_wdata;
    end
    if (pop) begin
      child_rd_r  <= child_mem[top_addr];
      parent_rd_r <= child_mem[par_addr];
    end
  end

  // Configuration registers
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b0;
      threshold_r <= '0;
      session_r   <= '0;
    end else if (cfg_wr) begin
      unique case (paddr)
        REG_ENABLE:    enable_r    <= pwdata[0];
        REG_THRESHOLD: threshold_r <= pwdata;
        REG_SESSION:   session_r   <= pwdata;
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      REG_ENABLE:    prdata = {{(CFG_DATA_W-1){1'b0}}, enable_r};
      REG_THRESHOLD: prdata = threshold_r;
      REG_SESSION:   prdata = session_r;
      default:       prdata = '0;
    endcase
  end

  // Datapath registers of the request and the exit path
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_id_r     <= in_chan.func_id;
      req_time_r   <= in_chan.timestamp_ns;
      req_mem_r    <= in_chan.mem_usage;
      parent_r     <= par_addr;
      has_parent_r <= (top_addr != '0);
    end
    if (state_r == S_RD) begin
      incl_r   <= req_time_r - frame_rd_r.base_time;
      mdelta_r <= {1'b0, req_mem_r} - {1'b0, frame_rd_r.base_mem};
      fid_r    <= frame_rd_r.func;
    end
  end

  // Sequencer, stack counters and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      level_r     <= '0;
      skip_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Hold a new record, else drop the one the receiver took
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && enable_r) begin
            priority if (is_enter && full) begin
              if (skip_r != SKIP_MAX) begin
                skip_r <= skip_r + SKIP_W'(1);
              end
            end else if (is_enter) begin
              level_r <= level_r + LVL_W'(1);
              state_r <= S_ENTER;
            end else if (skip_r != '0) begin
              skip_r <= skip_r - SKIP_W'(1);
            end else if (level_r != '0) begin
              level_r <= level_r - LVL_W'(1);
              state_r <= S_RD;
            end else begin
              // drop an exit on an empty stack
            end
          end
        end
        S_ENTER: begin
          if (out_free) begin
            out_kind_r    <= KIND_ENTER;
            out_id_r      <= req_id_r;
            out_incl_r    <= '0;
            out_excl_r    <= '0;
            out_delta_r   <= '0;
            out_session_r <= session_r;
            state_r       <= S_IDLE;
          end
        end
        S_RD: begin
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (fin_go) begin
            if (emit) begin
              out_kind_r    <= KIND_EXIT;
              out_id_r      <= fid_r;
              out_incl_r    <= incl_r;
              out_excl_r    <= excl;
              out_delta_r   <= mdelta_r;
              out_session_r <= session_r;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.event_kind   = out_kind_r;
  assign out_chan.out_func_id  = out_id_r;
  assign out_chan.inclusive_ns = out_incl_r;
  assign out_chan.exclusive_ns = out_excl_r;
  assign out_chan.mem_diff     = out_delta_r;
  assign out_chan.session      = out_session_r;

  // Check stack bounds, skip bookkeeping and sequencing
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LVL_W'(STACK_DEPTH))
    else $error("stack level beyond depth");

  a_skip_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    skip_r != '0 |-> full)
    else $error("skipped nesting while stack not full");

  a_pop_reads: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> state_r == S_RD && level_r == $past(level_r) - LVL_W'(1))
    else $error("pop did not start the exit sequence");

  a_record_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_ENTER || state_r == S_FIN))
    else $error("record issued outside enter or finish step");

endmodule
